/* rtl/core/mecanum_inverse_kinematics_unit_defines.svh */
// Assertion macros shared by the mecanum inverse kinematics RTL.
`ifndef MECANUM_INVERSE_KINEMATICS_UNIT_DEFINES_SVH
`define MECANUM_INVERSE_KINEMATICS_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define MIK_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define MIK_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/mik_pkg.sv */
// Types and constants shared by the mecanum inverse kinematics pipeline.
`default_nettype none
package mik_pkg;

	localparam int VEL_WIDTH = 16;
	localparam int MAG_W     = VEL_WIDTH;
	localparam int SQ_W      = 2 * VEL_WIDTH;
	localparam int LIM_W     = 15;
	localparam int OFS_W     = 12;
	localparam int GAIN_W    = 32;
	localparam int TMO_W     = 16;
	localparam int AGE_W     = 16;
	localparam int OUT_W     = 32;
	localparam int IDX_W     = 8;
	localparam int DATA_W    = 32;

	// Division by 1000 as a reciprocal multiply, exact for products below 2^KWP_W.
	localparam int KWP_W    = OFS_W + LIM_W;
	localparam int RECIP_SH = KWP_W + 10;
	localparam int RECIP_W  = RECIP_SH - 9;
	localparam logic [RECIP_W-1:0] RECIP_1000 =
		RECIP_W'(((64'd1 << RECIP_SH) + 64'd999) / 64'd1000);
	localparam int KWQ_W = KWP_W + RECIP_W;
	localparam int KW_W  = KWP_W - 9;

	localparam int SUM_W = ((MAG_W > KW_W) ? MAG_W + 1 : KW_W + 1) + 2;
	localparam int GAIN_FRAC = 16;

	typedef enum logic [IDX_W-1:0] {
		REG_LIN_LIMIT  = 8'd0,
		REG_TURN_LIMIT = 8'd1,
		REG_OFFSET     = 8'd2,
		REG_GAIN       = 8'd3,
		REG_TIMEOUT    = 8'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [VEL_WIDTH-1:0] vel_x;
		logic signed [VEL_WIDTH-1:0] vel_y;
		logic signed [VEL_WIDTH-1:0] turn_rate;
		logic        [AGE_W-1:0]     command_age;
	} cmd_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] front_left_rate;
		logic signed [OUT_W-1:0] front_right_rate;
		logic signed [OUT_W-1:0] rear_left_rate;
		logic signed [OUT_W-1:0] rear_right_rate;
		logic                    braked;
	} wheel_t;

	typedef struct packed {
		logic [LIM_W-1:0]  lin_speed_limit;
		logic [LIM_W-1:0]  turn_rate_limit;
		logic [OFS_W-1:0]  wheel_offset_sum;
		logic [GAIN_W-1:0] wheel_gain;
		logic [TMO_W-1:0]  timeout_ms;
	} cfg_t;

	// Data that rides alongside the square root and the scaling divider.
	typedef struct packed {
		logic             sx;
		logic             sy;
		logic             sw;
		logic [MAG_W-1:0] ax;
		logic [MAG_W-1:0] ay;
		logic [KW_W-1:0]  kw;
		logic             stale;
	} side_t;

endpackage
`default_nettype wire

/* rtl/core/mik_prep.sv */
// Front stages: magnitudes, yaw clamp, staleness, squares and the yaw term.
`default_nettype none
module mik_prep
	import mik_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire cmd_t        in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [SQ_W-1:0]  out_sq,
	output side_t            out_side
);

	logic             vld_s1, vld_s2, vld_s3;
	logic             rdy1, rdy2, rdy3;
	logic [MAG_W-1:0] ax, ay, aw;
	logic [LIM_W-1:0] awc;
	logic             over;

	side_t             side_s1, side_s2, side_s3;
	logic [LIM_W-1:0]  awc_s1;
	logic [SQ_W-1:0]   sqx_s2, sqy_s2, sum_s3;
	logic [KWP_W-1:0]  kwp_s2;
	logic [KWQ_W-1:0]  kwq_s3;

	assign rdy3     = !vld_s3 || out_ready;
	assign rdy2     = !vld_s2 || rdy3;
	assign rdy1     = !vld_s1 || rdy2;
	assign in_ready = rdy1;

	assign ax   = in_data.vel_x[VEL_WIDTH-1] ? (~in_data.vel_x + 1'b1) : in_data.vel_x;
	assign ay   = in_data.vel_y[VEL_WIDTH-1] ? (~in_data.vel_y + 1'b1) : in_data.vel_y;
	assign aw   = in_data.turn_rate[VEL_WIDTH-1] ?
		(~in_data.turn_rate + 1'b1) : in_data.turn_rate;
	assign over = 32'(aw) > 32'(cfg.turn_rate_limit);
	assign awc  = over ? cfg.turn_rate_limit : LIM_W'(aw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= in_valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			side_s1.sx    <= in_data.vel_x[VEL_WIDTH-1];
			side_s1.sy    <= in_data.vel_y[VEL_WIDTH-1];
			side_s1.sw    <= in_data.turn_rate[VEL_WIDTH-1];
			side_s1.ax    <= ax;
			side_s1.ay    <= ay;
			side_s1.kw    <= '0;
			side_s1.stale <= in_data.command_age > cfg.timeout_ms;
			awc_s1        <= awc;
		end
		if (rdy2) begin
			side_s2 <= side_s1;
			sqx_s2  <= SQ_W'(side_s1.ax) * SQ_W'(side_s1.ax);
			sqy_s2  <= SQ_W'(side_s1.ay) * SQ_W'(side_s1.ay);
			kwp_s2  <= KWP_W'(cfg.wheel_offset_sum) * KWP_W'(awc_s1);
		end
		if (rdy3) begin
			side_s3 <= side_s2;
			sum_s3  <= sqx_s2 + sqy_s2;
			kwq_s3  <= KWQ_W'(kwp_s2) * KWQ_W'(RECIP_1000);
		end
	end

	assign out_valid = vld_s3;
	assign out_sq    = sum_s3;

	always_comb begin
		out_side    = side_s3;
		out_side.kw = KW_W'(kwq_s3 >> RECIP_SH);
	end

endmodule
`default_nettype wire

/* rtl/core/mik_sqrt.sv */
// Integer square root, one result bit per pipeline stage.
`default_nettype none
`include "mecanum_inverse_kinematics_unit_defines.svh"
module mik_sqrt
	import mik_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [SQ_W-1:0] in_x,
	input  wire side_t        in_side,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [MAG_W-1:0]  out_root,
	output side_t             out_side
);

	localparam int N  = SQ_W / 2;
	localparam int RW = MAG_W + 2;
	localparam int TW = RW + 2;

	logic [N-1:0]      vld_s;
	logic [N-1:0]      rdy;
	logic [SQ_W-1:0]   x_s    [N];
	logic [MAG_W-1:0]  root_s [N];
	logic [RW-1:0]     rem_s  [N];
	side_t             side_s [N];

	assign in_ready = rdy[0];

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic              p_vld;
		logic [SQ_W-1:0]   p_x;
		logic [MAG_W-1:0]  p_root;
		logic [RW-1:0]     p_rem;
		side_t             p_side;
		logic              nxt_rdy;
		logic [TW-1:0]     t, trial;
		logic              ge;

		if (i == 0) begin : g_first
			assign p_vld  = in_valid;
			assign p_x    = in_x;
			assign p_root = '0;
			assign p_rem  = '0;
			assign p_side = in_side;
		end else begin : g_next
			assign p_vld  = vld_s[i-1];
			assign p_x    = x_s[i-1];
			assign p_root = root_s[i-1];
			assign p_rem  = rem_s[i-1];
			assign p_side = side_s[i-1];
		end

		if (i == N - 1) begin : g_last
			assign nxt_rdy = out_ready;
		end else begin : g_mid
			assign nxt_rdy = rdy[i+1];
		end

		assign rdy[i] = !vld_s[i] || nxt_rdy;
		assign t      = {p_rem, p_x[SQ_W-1 -: 2]};
		assign trial  = TW'({p_root, 2'b01});
		assign ge     = t >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (rdy[i]) begin
				vld_s[i] <= p_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[i]) begin
				x_s[i]    <= p_x << 2;
				root_s[i] <= {p_root[MAG_W-2:0], ge};
				rem_s[i]  <= ge ? RW'(t - trial) : RW'(t);
				side_s[i] <= p_side;
			end
		end
	end

	assign out_valid = vld_s[N-1];
	assign out_root  = root_s[N-1];
	assign out_side  = side_s[N-1];

	// The remainder of a correct root never exceeds twice the root.
	`MIK_ASSERT_IMP(a_sqrt_rem, out_valid, rem_s[N-1] <= RW'({out_root, 1'b0}), "sqrt remainder too large")

endmodule
`default_nettype wire

/* rtl/core/mik_scale.sv */
// Planar speed limit: component times limit, divided by the magnitude bit by bit.
`default_nettype none
module mik_scale
	import mik_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire cfg_t         cfg,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [MAG_W-1:0] in_root,
	input  wire side_t        in_side,
	output logic              out_valid,
	input  wire logic         out_ready,
	output side_t             out_side
);

	localparam int N  = LIM_W + 1;
	localparam int PW = MAG_W + LIM_W;

	logic [N-1:0]      vld_s;
	logic [N-1:0]      rdy;
	logic [MAG_W-1:0]  m_s    [N];
	logic [MAG_W-1:0]  remx_s [N];
	logic [MAG_W-1:0]  remy_s [N];
	logic [LIM_W-1:0]  dlx_s  [N];
	logic [LIM_W-1:0]  dly_s  [N];
	logic [LIM_W-1:0]  qx_s   [N];
	logic [LIM_W-1:0]  qy_s   [N];
	logic [N-1:0]      need_s;
	side_t             side_s [N];

	logic [PW-1:0]     px, py;

	assign in_ready = rdy[0];
	assign px = PW'(in_side.ax) * PW'(cfg.lin_speed_limit);
	assign py = PW'(in_side.ay) * PW'(cfg.lin_speed_limit);

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic nxt_rdy;

		if (i == N - 1) begin : g_last
			assign nxt_rdy = out_ready;
		end else begin : g_mid
			assign nxt_rdy = rdy[i+1];
		end
		assign rdy[i] = !vld_s[i] || nxt_rdy;

		if (i == 0) begin : g_mult
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[i] <= 1'b0;
				end else if (rdy[i]) begin
					vld_s[i] <= in_valid;
				end
			end

			always_ff @(posedge clk) begin
				if (rdy[i]) begin
					m_s[i]    <= in_root;
					need_s[i] <= 32'(in_root) > 32'(cfg.lin_speed_limit);
					remx_s[i] <= px[PW-1:LIM_W];
					remy_s[i] <= py[PW-1:LIM_W];
					dlx_s[i]  <= px[LIM_W-1:0];
					dly_s[i]  <= py[LIM_W-1:0];
					qx_s[i]   <= '0;
					qy_s[i]   <= '0;
					side_s[i] <= in_side;
				end
			end
		end else begin : g_div
			logic [MAG_W:0] tx, ty;
			logic           gx, gy;

			assign tx = {remx_s[i-1], dlx_s[i-1][LIM_W-1]};
			assign ty = {remy_s[i-1], dly_s[i-1][LIM_W-1]};
			assign gx = tx >= {1'b0, m_s[i-1]};
			assign gy = ty >= {1'b0, m_s[i-1]};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[i] <= 1'b0;
				end else if (rdy[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end

			always_ff @(posedge clk) begin
				if (rdy[i]) begin
					m_s[i]    <= m_s[i-1];
					need_s[i] <= need_s[i-1];
					remx_s[i] <= gx ? MAG_W'(tx - {1'b0, m_s[i-1]}) : MAG_W'(tx);
					remy_s[i] <= gy ? MAG_W'(ty - {1'b0, m_s[i-1]}) : MAG_W'(ty);
					dlx_s[i]  <= dlx_s[i-1] << 1;
					dly_s[i]  <= dly_s[i-1] << 1;
					qx_s[i]   <= {qx_s[i-1][LIM_W-2:0], gx};
					qy_s[i]   <= {qy_s[i-1][LIM_W-2:0], gy};
					side_s[i] <= side_s[i-1];
				end
			end
		end
	end

	assign out_valid = vld_s[N-1];

	always_comb begin
		out_side = side_s[N-1];
		if (need_s[N-1]) begin
			out_side.ax = MAG_W'(qx_s[N-1]);
			out_side.ay = MAG_W'(qy_s[N-1]);
		end
	end

endmodule
`default_nettype wire

/* rtl/core/mik_wheel.sv */
// Wheel mixing, gain multiply, saturation and the output register.
`default_nettype none
module mik_wheel
	import mik_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire side_t in_side,
	output logic       out_valid,
	input  wire logic  out_ready,
	output wheel_t     out_data
);

	localparam int PROD_W = SUM_W + GAIN_W;
	localparam int P_W    = PROD_W - GAIN_FRAC;

	function automatic logic [OUT_W-1:0] sat_rate(input logic neg, input logic [P_W-1:0] p);
		logic [OUT_W-1:0] r;
		if (neg) begin
			r = (p > P_W'(32'h8000_0000)) ? 32'h8000_0000 : (~p[OUT_W-1:0] + 1'b1);
		end else begin
			r = (p > P_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : p[OUT_W-1:0];
		end
		return r;
	endfunction

	logic vld_s1, vld_s2, vld_s3;
	logic rdy1, rdy2, rdy3;

	logic signed [SUM_W-1:0] vx, vy, kw;
	logic signed [SUM_W-1:0] sum_s1 [4];
	logic                    stale_s1, stale_s2;
	logic [PROD_W-1:0]       prod_s2 [4];
	logic [3:0]              neg_s2;
	wheel_t                  out_s3;

	assign rdy3     = !vld_s3 || out_ready;
	assign rdy2     = !vld_s2 || rdy3;
	assign rdy1     = !vld_s1 || rdy2;
	assign in_ready = rdy1;

	assign vx = in_side.sx ? -signed'(SUM_W'(in_side.ax)) : signed'(SUM_W'(in_side.ax));
	assign vy = in_side.sy ? -signed'(SUM_W'(in_side.ay)) : signed'(SUM_W'(in_side.ay));
	assign kw = in_side.sw ? -signed'(SUM_W'(in_side.kw)) : signed'(SUM_W'(in_side.kw));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= in_valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			sum_s1[0] <= vx - vy - kw;
			sum_s1[1] <= vx + vy + kw;
			sum_s1[2] <= vx + vy - kw;
			sum_s1[3] <= vx - vy + kw;
			stale_s1  <= in_side.stale;
		end
		if (rdy2) begin
			for (int k = 0; k < 4; k++) begin
				neg_s2[k]  <= sum_s1[k][SUM_W-1];
				prod_s2[k] <= PROD_W'(sum_s1[k][SUM_W-1] ? -sum_s1[k] : sum_s1[k]) *
					PROD_W'(cfg.wheel_gain);
			end
			stale_s2 <= stale_s1;
		end
		if (rdy3) begin
			if (stale_s2) begin
				out_s3 <= '{default: '0, braked: 1'b1};
			end else begin
				out_s3.front_left_rate  <= sat_rate(neg_s2[0], prod_s2[0][PROD_W-1:GAIN_FRAC]);
				out_s3.front_right_rate <= sat_rate(neg_s2[1], prod_s2[1][PROD_W-1:GAIN_FRAC]);
				out_s3.rear_left_rate   <= sat_rate(neg_s2[2], prod_s2[2][PROD_W-1:GAIN_FRAC]);
				out_s3.rear_right_rate  <= sat_rate(neg_s2[3], prod_s2[3][PROD_W-1:GAIN_FRAC]);
				out_s3.braked           <= 1'b0;
			end
		end
	end

	assign out_valid = vld_s3;
	assign out_data  = out_s3;

endmodule
`default_nettype wire

/* rtl/core/mecanum_inverse_kinematics_unit.sv */
// Throughput: one command per cycle unless out_ready stalls the output; the
// 16-stage square root, one bit per stage, and the 16-stage scaling divider,
// a multiply stage then one quotient bit per stage, are fully pipelined.
// Reset: arst_n clears all valid bits and loads the register defaults.
// No clearing pass is needed; commands are taken straight after reset.
`default_nettype none
`include "mecanum_inverse_kinematics_unit_defines.svh"
module mecanum_inverse_kinematics_unit
	import mik_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [IDX_W-1:0]  cfg_index,
	input  wire logic [DATA_W-1:0] cfg_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire cmd_t              in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output wheel_t                 out_data
);

	// Configuration registers. Writes are always taken; an index beyond the
	// register list is simply ignored, and data is cut to the register width.
	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lin_speed_limit  <= LIM_W'(1000);
			cfg_q.turn_rate_limit  <= LIM_W'(1000);
			cfg_q.wheel_offset_sum <= OFS_W'(610);
			cfg_q.wheel_gain       <= GAIN_W'(58254);
			cfg_q.timeout_ms       <= TMO_W'(500);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LIN_LIMIT:  cfg_q.lin_speed_limit  <= cfg_data[LIM_W-1:0];
				REG_TURN_LIMIT: cfg_q.turn_rate_limit  <= cfg_data[LIM_W-1:0];
				REG_OFFSET:     cfg_q.wheel_offset_sum <= cfg_data[OFS_W-1:0];
				REG_GAIN:       cfg_q.wheel_gain       <= cfg_data[GAIN_W-1:0];
				REG_TIMEOUT:    cfg_q.timeout_ms       <= cfg_data[TMO_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Pipeline chain. Each stage holds its own valid bit and takes a new
	// transaction whenever it is empty or the stage after it moves on, so
	// bubbles close up and a stalled output does not stop the front filling.
	logic              prep_valid, prep_ready;
	logic [SQ_W-1:0]   prep_sq;
	side_t             prep_side;
	logic              sqrt_valid, sqrt_ready;
	logic [MAG_W-1:0]  sqrt_root;
	side_t             sqrt_side;
	logic              scale_valid, scale_ready;
	side_t             scale_side;

	// Magnitudes, yaw clamp, staleness, squares and the offset times yaw term.
	mik_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (prep_valid),
		.out_ready (prep_ready),
		.out_sq    (prep_sq),
		.out_side  (prep_side)
	);

	// Floor square root of the squared planar speed.
	mik_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (prep_valid),
		.in_ready  (prep_ready),
		.in_x      (prep_sq),
		.in_side   (prep_side),
		.out_valid (sqrt_valid),
		.out_ready (sqrt_ready),
		.out_root  (sqrt_root),
		.out_side  (sqrt_side)
	);

	// Scale both components by limit over magnitude when the limit is exceeded.
	mik_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (sqrt_valid),
		.in_ready  (sqrt_ready),
		.in_root   (sqrt_root),
		.in_side   (sqrt_side),
		.out_valid (scale_valid),
		.out_ready (scale_ready),
		.out_side  (scale_side)
	);

	// Wheel mixing, Q16.16 gain and saturation; its last stage is the
	// output register, and a stale command leaves it all zeros and braked.
	mik_wheel u_wheel (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (scale_valid),
		.in_ready  (scale_ready),
		.in_side   (scale_side),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// With the output free to move, every stage can move, so input is taken.
	`MIK_ASSERT_IMP(a_ready_chain, out_ready || !out_valid, in_ready, "input stalled with output free")
	// A braked result carries zero on every wheel.
	`MIK_ASSERT_IMP(a_brake_zero, out_valid && out_data.braked, (out_data.front_left_rate == '0) && (out_data.front_right_rate == '0) && (out_data.rear_left_rate == '0) && (out_data.rear_right_rate == '0), "braked result with nonzero rate")

endmodule
`default_nettype wire
